// ===== rtl/glr_pkg.sv =====
// Shared types and constants for the gradient line rasterizer.
package glr_pkg;

    localparam int COORD_W   = 6;   // pixel coordinate width
    localparam int RGB_W     = 16;  // RGB565 word
    localparam int CH_W      = 6;   // lane width for one color channel (green is widest)
    localparam int NUM_CH    = 3;   // red, green, blue
    localparam int R_LSB     = 11;
    localparam int G_LSB     = 5;
    localparam int RB_W      = 5;   // red and blue channel width
    localparam int G_W       = 6;
    localparam int DIV_STEPS = CH_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } glr_state_t;

    typedef struct packed {
        logic load;       // latch and orient a new line command
        logic div_start;  // start the channel dividers
        logic emit;       // push current pixel to the output register and step
    } glr_cmd_t;

    typedef struct packed {
        logic zero_len;   // line has no major-axis extent
        logic div_done;   // quotients and remainders are valid
        logic is_last;    // current pixel is the final one
        logic out_free;   // output register can take a word this cycle
    } glr_status_t;

endpackage

// ===== rtl/gradient_line_rasterizer.sv =====
// Flow: a line word is accepted, set up, run through the channel divider (skipped for
// zero-length lines), then stepped out by the Bresenham stepper at one pixel word per cycle
// while m_tready is high.  A new line word is accepted only once the last pixel is emitted.
// Reset: aresetn is synchronous, active low; it returns the sequencer to idle and empties
// the output register.  Line and color registers are not reset.
module gradient_line_rasterizer
    import glr_pkg::*;
#(
    parameter int CANVAS_SIZE = 64   // cap on pixels per line
)
(
    input  logic        aclk,
    input  logic        aresetn,
    // line command word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18],
                                   // start_rgb[39:24], end_rgb[55:40]
    // pixel word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_x[5:0], pixel_y[11:6], pixel_rgb[27:12], zero[31:28]
    output logic        m_tlast    // last_pixel
);

    glr_cmd_t    cmd;
    glr_status_t status;

    logic [COORD_W-1:0] pixel_x, pixel_y;
    logic [RGB_W-1:0]   pixel_rgb;

    // controller: IDLE -> PREP -> DIV -> EMIT, zero-length lines skip DIV
    glr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: orientation and swap at load, then per-pixel stepping
    glr_datapath #(
        .CANVAS_SIZE (CANVAS_SIZE)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .start_x    (s_tdata[5:0]),
        .start_y    (s_tdata[11:6]),
        .end_x      (s_tdata[17:12]),
        .end_y      (s_tdata[23:18]),
        .start_rgb  (s_tdata[39:24]),
        .end_rgb    (s_tdata[55:40]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_rgb  (pixel_rgb),
        .last_pixel (m_tlast)
    );

    assign m_tdata = {4'b0000, pixel_rgb, pixel_y, pixel_x};

endmodule

// ===== rtl/glr_div.sv =====
// Restoring divider, three lanes sharing one divisor, one quotient bit per cycle.
module glr_div
    import glr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [CH_W-1:0]           divisor,
    input  logic [NUM_CH-1:0][CH_W-1:0] numer,
    output logic [NUM_CH-1:0][CH_W-1:0] quot,
    output logic [NUM_CH-1:0][CH_W-1:0] rem,
    output logic                      done
);

    logic [NUM_CH-1:0][CH_W-1:0] num_reg, num_next;   // numerator in, quotient out
    logic [NUM_CH-1:0][CH_W-1:0] rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]        cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    always_comb begin
        logic [CH_W:0] trial;
        for (int i = 0; i < NUM_CH; i++) begin
            trial = {rem_reg[i], num_reg[i][CH_W-1]};
            if (trial >= {1'b0, divisor}) begin
                rem_next[i] = CH_W'(trial - {1'b0, divisor});
                num_next[i] = {num_reg[i][CH_W-2:0], 1'b1};
            end else begin
                rem_next[i] = trial[CH_W-1:0];
                num_next[i] = {num_reg[i][CH_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= numer;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign quot = num_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// ===== rtl/glr_datapath.sv =====
// Line setup, Bresenham stepper, color channel steppers and output register.
module glr_datapath
    import glr_pkg::*;
#(
    parameter int CANVAS_SIZE = 64
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  glr_cmd_t           cmd,
    output glr_status_t        status,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic [RGB_W-1:0]   start_rgb,
    input  logic [RGB_W-1:0]   end_rgb,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [COORD_W-1:0] pixel_x,
    output logic [COORD_W-1:0] pixel_y,
    output logic [RGB_W-1:0]   pixel_rgb,
    output logic               last_pixel
);

    localparam int unsigned CAP = CANVAS_SIZE - 1;  // highest pixel index in a line

    // setup, combinational from the input word
    logic signed [COORD_W:0] sx_diff, sy_diff;
    logic [COORD_W-1:0] adx, ady;
    logic               steep;
    logic [COORD_W-1:0] a0, b0, a1, b1;
    logic               swap;
    logic [COORD_W-1:0] ma0, mb0, mb1, mdx, mdy;
    logic               yneg;
    logic [RGB_W-1:0]   c0, c1;
    logic [NUM_CH-1:0][CH_W-1:0] ch_from, ch_to, ch_mag;
    logic [NUM_CH-1:0]           ch_neg;

    // line state
    logic [COORD_W-1:0] a_reg, b_reg, dx_reg, dy_reg, k_reg;
    logic               yneg_reg, steep_reg;
    logic signed [COORD_W:0] berr_reg;
    logic [NUM_CH-1:0][CH_W-1:0] val_reg, mag_reg;
    logic [NUM_CH-1:0]           neg_reg;
    logic signed [CH_W:0]        cerr_reg [NUM_CH];

    // divider results
    logic [NUM_CH-1:0][CH_W-1:0] quot, rem;
    logic                        div_done;

    // output register
    logic               out_valid_reg;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic [RGB_W-1:0]   rgb_reg;
    logic               last_reg;

    logic [COORD_W-1:0] lim;
    logic               is_last;
    logic [COORD_W-1:0] cur_px, cur_py;
    logic [RGB_W-1:0]   cur_rgb;
    logic signed [COORD_W:0] berr_dec;

    always_comb begin
        logic signed [CH_W:0] cdiff;
        sx_diff = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
        sy_diff = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
        adx = sx_diff[COORD_W] ? COORD_W'(-sx_diff) : sx_diff[COORD_W-1:0];
        ady = sy_diff[COORD_W] ? COORD_W'(-sy_diff) : sy_diff[COORD_W-1:0];
        steep = ady > adx;
        a0 = steep ? start_y : start_x;
        b0 = steep ? start_x : start_y;
        a1 = steep ? end_y   : end_x;
        b1 = steep ? end_x   : end_y;
        swap = a0 > a1;
        ma0 = swap ? a1 : a0;
        mb0 = swap ? b1 : b0;
        mb1 = swap ? b0 : b1;
        mdx = swap ? a0 - a1 : a1 - a0;
        yneg = mb0 > mb1;
        mdy = yneg ? mb0 - mb1 : mb1 - mb0;
        c0 = swap ? end_rgb : start_rgb;
        c1 = swap ? start_rgb : end_rgb;
        ch_from[CH_R] = {1'b0, c0[R_LSB +: RB_W]};
        ch_from[CH_G] = c0[G_LSB +: G_W];
        ch_from[CH_B] = {1'b0, c0[0 +: RB_W]};
        ch_to[CH_R]   = {1'b0, c1[R_LSB +: RB_W]};
        ch_to[CH_G]   = c1[G_LSB +: G_W];
        ch_to[CH_B]   = {1'b0, c1[0 +: RB_W]};
        for (int i = 0; i < NUM_CH; i++) begin
            cdiff = $signed({1'b0, ch_to[i]}) - $signed({1'b0, ch_from[i]});
            ch_neg[i] = cdiff[CH_W];
            ch_mag[i] = cdiff[CH_W] ? CH_W'(-cdiff) : cdiff[CH_W-1:0];
        end
    end

    glr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .divisor (dx_reg),
        .numer   (mag_reg),
        .quot    (quot),
        .rem     (rem),
        .done    (div_done)
    );

    // pixel count is capped at the canvas size
    always_comb begin
        lim     = (int'(dx_reg) > CAP) ? COORD_W'(CAP) : dx_reg;
        is_last = (k_reg == lim);
        cur_px  = steep_reg ? b_reg : a_reg;
        cur_py  = steep_reg ? a_reg : b_reg;
        cur_rgb = {val_reg[CH_R][RB_W-1:0], val_reg[CH_G][G_W-1:0], val_reg[CH_B][RB_W-1:0]};
        berr_dec = berr_reg - $signed({1'b0, dy_reg});
    end

    always_ff @(posedge aclk) begin
        logic signed [CH_W:0] e;
        logic [CH_W-1:0]      inc;
        if (cmd.load) begin
            a_reg     <= ma0;
            b_reg     <= mb0;
            dx_reg    <= mdx;
            dy_reg    <= mdy;
            yneg_reg  <= yneg;
            steep_reg <= steep;
            k_reg     <= '0;
            berr_reg  <= $signed({2'b00, mdx[COORD_W-1:1]});
            for (int i = 0; i < NUM_CH; i++) begin
                val_reg[i]  <= ch_from[i];
                mag_reg[i]  <= ch_mag[i];
                neg_reg[i]  <= ch_neg[i];
                cerr_reg[i] <= $signed({2'b00, mdx[COORD_W-1:1]});
            end
        end else if (cmd.emit) begin
            a_reg <= a_reg + 1'b1;
            k_reg <= k_reg + 1'b1;
            if (berr_dec < 0) begin
                b_reg    <= yneg_reg ? b_reg - 1'b1 : b_reg + 1'b1;
                berr_reg <= berr_dec + $signed({1'b0, dx_reg});
            end else begin
                berr_reg <= berr_dec;
            end
            for (int i = 0; i < NUM_CH; i++) begin
                e   = cerr_reg[i] - $signed({1'b0, rem[i]});
                inc = quot[i] + CH_W'(e < 0);
                val_reg[i]  <= neg_reg[i] ? val_reg[i] - inc : val_reg[i] + inc;
                cerr_reg[i] <= (e < 0) ? e + $signed({1'b0, dx_reg}) : e;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            px_reg   <= cur_px;
            py_reg   <= cur_py;
            rgb_reg  <= cur_rgb;
            last_reg <= is_last;
        end
    end

    assign status.zero_len = (dx_reg == '0);
    assign status.div_done = div_done;
    assign status.is_last  = is_last;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign pixel_rgb  = rgb_reg;
    assign last_pixel = last_reg;

endmodule

// ===== rtl/glr_ctrl.sv =====
// Sequencer for one line command: accept, divide, then emit pixels.
module glr_ctrl
    import glr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  glr_status_t status,
    output glr_cmd_t    cmd
);

    glr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (status.zero_len) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/glr_checker.sv =====
// Port-level assertions for the gradient line rasterizer, bound to the top level.
module glr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // stalled pixel word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("pixel word changed while stalled");

    // reset leaves the block idle with nothing to send
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");

    // one line at a time: no new command right after one is taken
    a_one_line: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while a line is in setup");

    // while a non-final pixel waits, the line is still running
    a_busy_mid_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("command port open in the middle of a line");

endmodule

bind gradient_line_rasterizer glr_checker u_glr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== verif/tb_gradient_line_rasterizer.sv =====
// Self-checking testbench for the gradient line rasterizer: line words in, checked pixel words out.
`timescale 1ns / 1ps

module tb_gradient_line_rasterizer;
    import glr_pkg::*;

    localparam int CANVAS       = 64;
    localparam int N_DIR        = 22;
    localparam int N_RAND       = 340;
    localparam int CALM_FROM    = N_RAND - 40;   // no idling on either side from here on
    localparam int STALL_AT     = 60;
    localparam int DRAIN_AT     = 200;
    localparam int STALL_CYCLES = 250;
    localparam int TAIL_CYCLES  = 24;
    localparam int PRINT_MAX    = 40;

    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [RGB_W-1:0]   c0;
        logic [RGB_W-1:0]   c1;
    } line_cmd_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RGB_W-1:0]   rgb;
        logic               last;
    } pixel_t;

    typedef struct packed {
        line_cmd_t cmd;
        logic      typed;   // expected pixel given below instead of predicted
        pixel_t    px;
    } dir_row_t;

    localparam pixel_t NO_PX = '0;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;    // start_x, start_y, end_x, end_y, start_rgb, end_rgb
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // pixel_x, pixel_y, pixel_rgb, zero pad
    logic        m_tlast;

    pixel_t pixel_q [$];
    int     fail_count = 0;
    int     pixel_count = 0;
    bit     calm = 1'b0;
    bit     stall_req = 1'b0;

    always #5 aclk = ~aclk;

    gradient_line_rasterizer #(
        .CANVAS_SIZE (CANVAS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Zero-length rows carry their pixel; the rest go through plot_line.
    dir_row_t dir_rows [N_DIR] = '{
        '{'{6'd0,  6'd0,  6'd0,  6'd0,  16'h0000, 16'hFFFF}, 1'b1,
          '{6'd0,  6'd0,  16'h0000, 1'b1}},
        '{'{6'd63, 6'd63, 6'd63, 6'd63, 16'hFFFF, 16'h0000}, 1'b1,
          '{6'd63, 6'd63, 16'hFFFF, 1'b1}},
        '{'{6'd21, 6'd42, 6'd21, 6'd42, 16'hA5A5, 16'h5A5A}, 1'b1,
          '{6'd21, 6'd42, 16'hA5A5, 1'b1}},
        '{'{6'd0,  6'd0,  6'd63, 6'd0,  16'h0000, 16'hFFFF}, 1'b0, NO_PX},
        '{'{6'd63, 6'd63, 6'd0,  6'd63, 16'hFFFF, 16'h0000}, 1'b0, NO_PX},
        '{'{6'd0,  6'd0,  6'd0,  6'd63, 16'hF800, 16'h001F}, 1'b0, NO_PX},
        '{'{6'd63, 6'd63, 6'd63, 6'd0,  16'h07E0, 16'hF81F}, 1'b0, NO_PX},
        '{'{6'd0,  6'd0,  6'd63, 6'd63, 16'h0000, 16'hFFFF}, 1'b0, NO_PX},
        '{'{6'd0,  6'd63, 6'd63, 6'd0,  16'hFFFF, 16'h0000}, 1'b0, NO_PX},
        '{'{6'd10, 6'd20, 6'd50, 6'd30, 16'hF800, 16'h0000}, 1'b0, NO_PX},
        '{'{6'd5,  6'd2,  6'd12, 6'd60, 16'h07E0, 16'h0000}, 1'b0, NO_PX},
        '{'{6'd40, 6'd60, 6'd30, 6'd1,  16'h001F, 16'hF800}, 1'b0, NO_PX},
        '{'{6'd7,  6'd7,  6'd8,  6'd7,  16'h0000, 16'hFFFF}, 1'b0, NO_PX},
        '{'{6'd7,  6'd7,  6'd7,  6'd8,  16'hFFFF, 16'h0000}, 1'b0, NO_PX},
        '{'{6'd3,  6'd4,  6'd4,  6'd5,  16'h1234, 16'hFEDC}, 1'b0, NO_PX},
        '{'{6'd2,  6'd50, 6'd61, 6'd13, 16'h1234, 16'h1234}, 1'b0, NO_PX},
        '{'{6'd0,  6'd10, 6'd30, 6'd12, 16'h0000, 16'hF800}, 1'b0, NO_PX},
        '{'{6'd30, 6'd12, 6'd0,  6'd10, 16'h07E0, 16'h0000}, 1'b0, NO_PX},
        '{'{6'd1,  6'd1,  6'd62, 6'd3,  16'h001F, 16'h0000}, 1'b0, NO_PX},
        '{'{6'd0,  6'd0,  6'd63, 6'd1,  16'h0000, 16'h0821}, 1'b0, NO_PX},
        '{'{6'd0,  6'd32, 6'd63, 6'd31, 16'h0841, 16'h0000}, 1'b0, NO_PX},
        '{'{6'd32, 6'd0,  6'd33, 6'd63, 16'h8410, 16'h7BEF}, 1'b0, NO_PX}
    };

    // Bresenham walk with per-channel error-accumulating color steps.
    function automatic void plot_line(input line_cmd_t l);
        int x0, y0, x1, y1, t, dx, dy, err, ystep, n;
        int from [NUM_CH];
        int to   [NUM_CH];
        int val  [NUM_CH];
        int dlt  [NUM_CH];
        int quo  [NUM_CH];
        int rmd  [NUM_CH];
        int acc  [NUM_CH];
        logic [RGB_W-1:0] c0, c1;
        bit steep;
        pixel_t p;
        x0 = l.sx;
        y0 = l.sy;
        x1 = l.ex;
        y1 = l.ey;
        c0 = l.c0;
        c1 = l.c1;
        steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
        if (steep) begin
            t = x0; x0 = y0; y0 = t;
            t = x1; x1 = y1; y1 = t;
        end
        if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
            {c0, c1} = {c1, c0};
        end
        dx = x1 - x0;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        if (dx == 0) begin
            p.x    = COORD_W'(x0);
            p.y    = COORD_W'(y0);
            p.rgb  = c0;
            p.last = 1'b1;
            pixel_q.push_back(p);
            return;
        end
        from[CH_R] = c0[R_LSB +: RB_W];
        to[CH_R]   = c1[R_LSB +: RB_W];
        from[CH_G] = c0[G_LSB +: G_W];
        to[CH_G]   = c1[G_LSB +: G_W];
        from[CH_B] = c0[0 +: RB_W];
        to[CH_B]   = c1[0 +: RB_W];
        for (int c = 0; c < NUM_CH; c++) begin
            dlt[c] = to[c] - from[c];
            val[c] = from[c];
            quo[c] = dlt[c] / dx;
            rmd[c] = dlt[c] - quo[c] * dx;
            if (rmd[c] < 0)
                rmd[c] = -rmd[c];
            acc[c] = dx / 2;
        end
        err   = dx / 2;
        ystep = (y0 < y1) ? 1 : -1;
        n     = (dx + 1 > CANVAS) ? CANVAS : dx + 1;
        for (int k = 0; k < n; k++) begin
            p.x    = COORD_W'(steep ? y0 : x0);
            p.y    = COORD_W'(steep ? x0 : y0);
            p.rgb  = {val[CH_R][RB_W-1:0], val[CH_G][G_W-1:0], val[CH_B][RB_W-1:0]};
            p.last = (k == n - 1);
            pixel_q.push_back(p);
            err -= dy;
            if (err < 0) begin
                y0  += ystep;
                err += dx;
            end
            x0++;
            for (int c = 0; c < NUM_CH; c++) begin
                val[c] += quo[c];
                acc[c] -= rmd[c];
                if (acc[c] < 0) begin
                    val[c] += (dlt[c] > 0) ? 1 : -1;
                    acc[c] += dx;
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_MAX)
            $display("[%0t] pixel %0d %s: got %h, expected %h",
                     $realtime, pixel_count, what, got, want);
        fail_count++;
    endtask

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > 63) ? 63 : v;
    endfunction

    // Random idle burst on the line side; returns at once when no burst is drawn.
    task automatic line_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    task automatic push_line(input line_cmd_t l, input logic typed, input pixel_t px);
        s_tdata  <= {l.c1, l.c0, l.ey, l.ex, l.sy, l.sx};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (typed)
            pixel_q.push_back(px);
        else
            plot_line(l);
    endtask

    // Pixel side: random stalls, one long hold-off on request, always ready once calm.
    initial begin : pixel_sink
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (stall_req) begin
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
                stall_req = 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : pixel_check
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_q.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, '0);
            end else begin
                want = pixel_q.pop_front();
                if (m_tdata[5:0] !== want.x)
                    report_mismatch("pixel_x", m_tdata[5:0], want.x);
                if (m_tdata[11:6] !== want.y)
                    report_mismatch("pixel_y", m_tdata[11:6], want.y);
                if (m_tdata[27:12] !== want.rgb)
                    report_mismatch("pixel_rgb", m_tdata[27:12], want.rgb);
                if (m_tdata[31:28] !== 4'b0)
                    report_mismatch("pad", m_tdata[31:28], '0);
                if (m_tlast !== want.last)
                    report_mismatch("last_pixel", m_tlast, want.last);
            end
            pixel_count++;
        end
    end

    initial begin : watchdog
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stim
        line_cmd_t cmd;
        int mode, lx, ly, waited;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (6) @(posedge aclk);
        aresetn  <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIR; i++) begin
            line_gap();
            push_line(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].px);
        end

        for (int i = 0; i < N_RAND; i++) begin
            if (i == STALL_AT)
                stall_req = 1'b1;
            if (i == CALM_FROM)
                calm = 1'b1;
            if (i == DRAIN_AT) begin
                // let every pending pixel out before going on
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pixel_q.size() != 0);
            end else begin
                line_gap();
            end
            cmd.sx = COORD_W'($urandom_range(0, 63));
            cmd.sy = COORD_W'($urandom_range(0, 63));
            cmd.ex = COORD_W'($urandom_range(0, 63));
            cmd.ey = COORD_W'($urandom_range(0, 63));
            cmd.c0 = RGB_W'($urandom_range(0, 65535));
            cmd.c1 = RGB_W'($urandom_range(0, 65535));
            mode = $urandom_range(0, 9);
            case (mode) inside
                0: begin
                    cmd.ex = cmd.sx;
                    cmd.ey = cmd.sy;
                end
                [1:4]: begin
                    lx = cmd.sx + $urandom_range(0, 10) - 5;
                    ly = cmd.sy + $urandom_range(0, 10) - 5;
                    cmd.ex = COORD_W'(clamp_coord(lx));
                    cmd.ey = COORD_W'(clamp_coord(ly));
                end
                8: begin
                    // span the whole canvas on one axis
                    if ($urandom_range(0, 1)) begin
                        cmd.sx = '0;
                        cmd.ex = 6'd63;
                    end else begin
                        cmd.sy = 6'd63;
                        cmd.ey = '0;
                    end
                end
                9: begin
                    cmd.c0 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    cmd.c1 = ~cmd.c0;
                end
                default: ;
            endcase
            push_line(cmd, 1'b0, NO_PX);
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (pixel_q.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pixel_q.size() != 0)
            report_mismatch("pixels never sent", pixel_q.size(), '0);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
